FILE: hw/rtl/vrrb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrrb_pkg
// Shared types and constants for the variable record ring buffer.
// ----------------------------------------------------------------------------
package vrrb_pkg;

  localparam int BUFFER_BYTES_DEF = 4096;
  localparam int HEADER_BYTES_DEF = 8;

  // Fixed field widths of the stream payload
  localparam int LEN_W    = 12;
  localparam int REC_W    = 11;
  localparam int BYTE_W   = 8;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

  // Header type byte
  localparam logic [BYTE_W-1:0] HDR_NORMAL = 8'd1;
  localparam logic [BYTE_W-1:0] HDR_WRAP   = 8'd2;

  typedef enum logic [1:0] {
    CMD_WRITE_START = 2'd0,
    CMD_WRITE_BYTE  = 2'd1,
    CMD_READ_START  = 2'd2,
    CMD_READ_BYTE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_WRAP     = 3'd2,
    ST_FULL     = 3'd3,
    ST_TOO_LONG = 3'd4,
    ST_NO_XFER  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HDR_WR,
    S_HDR_RD,
    S_BYTE_RD,
    S_RESP
  } state_t;

endpackage

FILE: hw/rtl/variable_record_ring_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// variable_record_ring_buffer
// Byte ring that stores length-prefixed messages in one byte-wide RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel: tuser carries the command (write
//   start, write payload byte, read start, read payload byte), tdata the
//   message length and the payload byte. Every request returns exactly one
//   response on the m_axis channel: status, record length and read byte in
//   tdata, and tlast marking the end of a message transfer.
//   Requests are handled one at a time. A write payload byte is accepted and
//   then answered; a read payload byte adds a step for the registered RAM
//   read. A read start is accepted, runs three header read steps (type and
//   two length bytes, each in the cycle after its RAM read), then responds.
//   A write start that stores a header writes HEADER_BYTES header bytes, one
//   header byte a cycle through the single byte-wide RAM write port, then
//   responds. Rejected starts (too long, full, empty) go straight to respond.
//   The response register frees the input side: a new request is accepted
//   while the previous response waits for m_axis_tready; the block stalls in
//   its response step only when a second response is ready and the first one
//   has not yet been taken.
//   Reset clears head, tail, cursors and open transfers; the RAM is not
//   cleared, its contents are only read where a header or payload was written.
// ----------------------------------------------------------------------------
module variable_record_ring_buffer #(
  parameter int BUFFER_BYTES = vrrb_pkg::BUFFER_BYTES_DEF,
  parameter int HEADER_BYTES = vrrb_pkg::HEADER_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // Request channel
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [11:0] write_length, [19:12] payload_byte, [23:20] zero
  input  logic [vrrb_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // [1:0] cmd
  input  logic [1:0]                       s_axis_tuser,
  // Response channel
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [2:0] status, [13:3] record_length, [21:14] read_byte_value, [23:22] zero
  output logic [vrrb_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // last_byte
  output logic                             m_axis_tlast
);

  localparam int AW  = $clog2(BUFFER_BYTES);
  localparam int FW  = ((AW > vrrb_pkg::LEN_W) ? AW : vrrb_pkg::LEN_W) + 2;
  localparam int HCW = $clog2(HEADER_BYTES);
  localparam logic [AW-1:0]  LAST_ADDR  = AW'(BUFFER_BYTES - 1);
  localparam logic [FW-1:0]  BUF_F      = FW'(BUFFER_BYTES);
  localparam logic [FW-1:0]  HALF_F     = FW'(BUFFER_BYTES / 2);
  localparam logic [FW-1:0]  HDR3_F     = FW'(3 * HEADER_BYTES);
  localparam logic [AW:0]    BUF_X      = (AW+1)'(BUFFER_BYTES);
  localparam logic [AW:0]    HDR_X      = (AW+1)'(HEADER_BYTES);
  localparam logic [HCW-1:0] HDR_LAST   = HCW'(HEADER_BYTES - 1);

  // Advance a ring address by one, wrapping at the end of the ring
  function automatic logic [AW-1:0] addr_inc(input logic [AW-1:0] a);
    addr_inc = (a == LAST_ADDR) ? '0 : a + AW'(1);
  endfunction

  // Ring address just past a header
  function automatic logic [AW-1:0] addr_skip_hdr(input logic [AW-1:0] a);
    logic [AW:0] s;
    s = {1'b0, a} + HDR_X;
    if (s >= BUF_X) begin
      s = s - BUF_X;
    end
    addr_skip_hdr = s[AW-1:0];
  endfunction

  // Request fields
  vrrb_pkg::cmd_t                 in_cmd;
  logic [vrrb_pkg::LEN_W-1:0]     in_len;
  logic [vrrb_pkg::BYTE_W-1:0]    in_byte;

  assign in_cmd  = vrrb_pkg::cmd_t'(s_axis_tuser);
  assign in_len  = s_axis_tdata[11:0];
  assign in_byte = s_axis_tdata[19:12];

  // Control state
  vrrb_pkg::state_t               state, state_next;
  logic [AW-1:0]                  head, head_next;
  logic [AW-1:0]                  tail, tail_next;
  logic [AW-1:0]                  wr_cursor, wr_cursor_next;
  logic [vrrb_pkg::LEN_W-1:0]     wr_remaining, wr_remaining_next;
  logic [AW-1:0]                  rd_cursor, rd_cursor_next;
  logic [vrrb_pkg::LEN_W-1:0]     rd_remaining, rd_remaining_next;
  logic [HCW-1:0]                 cnt, cnt_next;
  logic                           m_valid_next;

  // Working registers of the current request
  logic [AW-1:0]                  op_addr, op_addr_next;
  logic [vrrb_pkg::LEN_W-1:0]     op_len, op_len_next;
  logic                           op_wrap, op_wrap_next;
  vrrb_pkg::status_t              res_status, res_status_next;
  logic [vrrb_pkg::REC_W-1:0]     res_len, res_len_next;
  logic [vrrb_pkg::BYTE_W-1:0]    res_val, res_val_next;
  logic                           res_last, res_last_next;
  logic [vrrb_pkg::OUT_TDATA_W-1:0] m_data_next;
  logic                           m_last_next;

  // RAM port
  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr;
  logic [vrrb_pkg::BYTE_W-1:0]    ram_wdata;
  logic                           ram_re;
  logic [AW-1:0]                  ram_raddr;
  logic [vrrb_pkg::BYTE_W-1:0]    ram_rdata;

  // Space check for a write start
  logic [FW-1:0]                  free_space;
  logic [FW-1:0]                  need_space;
  logic [vrrb_pkg::LEN_W-1:0]     hdr_len;

  always_comb begin
    if (head < tail) begin
      free_space = FW'(tail) - FW'(head);
    end else begin
      free_space = BUF_F - FW'(head);
    end
    need_space = FW'(in_len) + HDR3_F;
  end

  // Length as seen on the last header read cycle
  assign hdr_len = {ram_rdata[3:0], op_len[7:0]};

  assign s_axis_tready = (state == vrrb_pkg::S_IDLE);

  always_comb begin
    state_next        = state;
    head_next         = head;
    tail_next         = tail;
    wr_cursor_next    = wr_cursor;
    wr_remaining_next = wr_remaining;
    rd_cursor_next    = rd_cursor;
    rd_remaining_next = rd_remaining;
    cnt_next          = cnt;
    op_addr_next      = op_addr;
    op_len_next       = op_len;
    op_wrap_next      = op_wrap;
    res_status_next   = res_status;
    res_len_next      = res_len;
    res_val_next      = res_val;
    res_last_next     = res_last;
    m_valid_next      = m_axis_tvalid & ~m_axis_tready;
    m_data_next       = m_axis_tdata;
    m_last_next       = m_axis_tlast;
    ram_we            = 1'b0;
    ram_waddr         = op_addr;
    ram_wdata         = '0;
    ram_re            = 1'b0;
    ram_raddr         = op_addr;

    case (state)
      vrrb_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          // Default response: rejected or plain ok, no length, no byte
          res_status_next = vrrb_pkg::ST_OK;
          res_len_next    = '0;
          res_val_next    = '0;
          res_last_next   = 1'b0;
          state_next      = vrrb_pkg::S_RESP;
          case (in_cmd)
            vrrb_pkg::CMD_WRITE_START: begin
              // A new start drops any open write
              wr_remaining_next = '0;
              op_len_next       = in_len;
              op_addr_next      = head;
              cnt_next          = '0;
              if (FW'(in_len) >= HALF_F) begin
                res_status_next = vrrb_pkg::ST_TOO_LONG;
              end else if (need_space < free_space) begin
                op_wrap_next = 1'b0;
                state_next   = vrrb_pkg::S_HDR_WR;
              end else if (tail != '0 && tail <= head) begin
                op_wrap_next = 1'b1;
                state_next   = vrrb_pkg::S_HDR_WR;
              end else begin
                res_status_next = vrrb_pkg::ST_FULL;
              end
            end
            vrrb_pkg::CMD_WRITE_BYTE: begin
              if (wr_remaining == '0) begin
                res_status_next = vrrb_pkg::ST_NO_XFER;
              end else begin
                ram_we            = 1'b1;
                ram_waddr         = wr_cursor;
                ram_wdata         = in_byte;
                wr_cursor_next    = addr_inc(wr_cursor);
                wr_remaining_next = wr_remaining - 1'b1;
                if (wr_remaining == vrrb_pkg::LEN_W'(1)) begin
                  // Commit the message
                  head_next     = addr_inc(wr_cursor);
                  res_last_next = 1'b1;
                end
              end
            end
            vrrb_pkg::CMD_READ_START: begin
              // A new start drops any open read
              rd_remaining_next = '0;
              if (head == tail) begin
                res_status_next = vrrb_pkg::ST_EMPTY;
              end else begin
                ram_re       = 1'b1;
                ram_raddr    = tail;
                op_addr_next = addr_inc(tail);
                cnt_next     = '0;
                state_next   = vrrb_pkg::S_HDR_RD;
              end
            end
            vrrb_pkg::CMD_READ_BYTE: begin
              if (rd_remaining == '0) begin
                res_status_next = vrrb_pkg::ST_NO_XFER;
              end else begin
                ram_re     = 1'b1;
                ram_raddr  = rd_cursor;
                state_next = vrrb_pkg::S_BYTE_RD;
              end
            end
            default: begin
              res_status_next = vrrb_pkg::ST_NO_XFER;
            end
          endcase
        end
      end

      vrrb_pkg::S_HDR_WR: begin
        // One header byte a cycle: type, length low, length high, zeros
        ram_we = 1'b1;
        case (cnt)
          HCW'(0): ram_wdata = op_wrap ? vrrb_pkg::HDR_WRAP : vrrb_pkg::HDR_NORMAL;
          HCW'(1): ram_wdata = op_len[7:0];
          HCW'(2): ram_wdata = {4'b0000, op_len[11:8]};
          default: ram_wdata = '0;
        endcase
        op_addr_next = addr_inc(op_addr);
        cnt_next     = cnt + 1'b1;
        if (cnt == HDR_LAST) begin
          state_next = vrrb_pkg::S_RESP;
          if (op_wrap) begin
            head_next       = '0;
            res_status_next = vrrb_pkg::ST_WRAP;
          end else begin
            wr_cursor_next    = addr_inc(op_addr);
            wr_remaining_next = op_len;
            if (op_len == '0) begin
              head_next     = addr_inc(op_addr);
              res_last_next = 1'b1;
            end
          end
        end
      end

      vrrb_pkg::S_HDR_RD: begin
        // Each read was issued in the cycle before: data here is header byte cnt
        cnt_next = cnt + 1'b1;
        if (cnt == HCW'(0)) begin
          op_wrap_next = (ram_rdata == vrrb_pkg::HDR_WRAP);
          ram_re       = 1'b1;
          op_addr_next = addr_inc(op_addr);
        end else if (cnt == HCW'(1)) begin
          op_len_next  = {4'b0000, ram_rdata};
          ram_re       = 1'b1;
        end else begin
          state_next = vrrb_pkg::S_RESP;
          if (op_wrap) begin
            tail_next       = '0;
            res_status_next = vrrb_pkg::ST_WRAP;
          end else begin
            rd_cursor_next    = addr_skip_hdr(tail);
            rd_remaining_next = hdr_len;
            if (hdr_len == '0) begin
              tail_next     = addr_skip_hdr(tail);
              res_last_next = 1'b1;
            end else begin
              res_len_next = hdr_len[vrrb_pkg::REC_W-1:0];
            end
          end
        end
      end

      vrrb_pkg::S_BYTE_RD: begin
        res_val_next      = ram_rdata;
        rd_cursor_next    = addr_inc(rd_cursor);
        rd_remaining_next = rd_remaining - 1'b1;
        if (rd_remaining == vrrb_pkg::LEN_W'(1)) begin
          // Release the message
          tail_next     = addr_inc(rd_cursor);
          res_last_next = 1'b1;
        end
        state_next = vrrb_pkg::S_RESP;
      end

      vrrb_pkg::S_RESP: begin
        // Hold until the response register is free
        if (!m_axis_tvalid || m_axis_tready) begin
          m_valid_next = 1'b1;
          m_data_next  = {2'b00, res_val, res_len, res_status};
          m_last_next  = res_last;
          state_next   = vrrb_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = vrrb_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= vrrb_pkg::S_IDLE;
      head          <= '0;
      tail          <= '0;
      wr_cursor     <= '0;
      wr_remaining  <= '0;
      rd_cursor     <= '0;
      rd_remaining  <= '0;
      cnt           <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state         <= state_next;
      head          <= head_next;
      tail          <= tail_next;
      wr_cursor     <= wr_cursor_next;
      wr_remaining  <= wr_remaining_next;
      rd_cursor     <= rd_cursor_next;
      rd_remaining  <= rd_remaining_next;
      cnt           <= cnt_next;
      m_axis_tvalid <= m_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op_addr      <= op_addr_next;
    op_len       <= op_len_next;
    op_wrap      <= op_wrap_next;
    res_status   <= res_status_next;
    res_len      <= res_len_next;
    res_val      <= res_val_next;
    res_last     <= res_last_next;
    m_axis_tdata <= m_data_next;
    m_axis_tlast <= m_last_next;
  end

  vrrb_ram #(
    .WIDTH (vrrb_pkg::BYTE_W),
    .DEPTH (BUFFER_BYTES)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

`ifndef SYNTHESIS
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    (FW'(head) < BUF_F) && (FW'(tail) < BUF_F)
    && (FW'(wr_cursor) < BUF_F) && (FW'(rd_cursor) < BUF_F))
    else $error("ring pointer outside the ring");

  a_wr_len: assert property (@(posedge clk) disable iff (rst)
    FW'(wr_remaining) < HALF_F)
    else $error("open write longer than half the ring");

  a_we_state: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == vrrb_pkg::S_IDLE || state == vrrb_pkg::S_HDR_WR))
    else $error("ring write outside a write step");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !ram_re)
    else $error("ring read and write in the same cycle");

  a_resp_load: assert property (@(posedge clk) disable iff (rst)
    (state == vrrb_pkg::S_RESP && (!m_axis_tvalid || m_axis_tready))
    |=> (m_axis_tvalid && state == vrrb_pkg::S_IDLE))
    else $error("response not loaded when the output was free");
`endif

endmodule

FILE: hw/rtl/vrrb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrrb_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module vrrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
